@@ sv/iabu_pkg.sv @@
// ----------------------------------------------------------------------------
// iabu_pkg: shared definitions for the integer add, logic and bit ALU
// opcodes, size codes, flag bit positions and the request/response payloads
// ----------------------------------------------------------------------------
package iabu_pkg;

    // datapath width of the operand and result fields
    localparam int DATA_W  = 32;
    localparam int FLAGS_W = 6;
    localparam int OP_W    = 4;
    localparam int SIZE_W  = 2;

    // bit index width for a dword operand
    localparam int IDX_W = $clog2(DATA_W);

    // opcodes
    localparam logic [OP_W-1:0] OP_ADD   = 4'd0;
    localparam logic [OP_W-1:0] OP_ADC   = 4'd1;
    localparam logic [OP_W-1:0] OP_AND   = 4'd2;
    localparam logic [OP_W-1:0] OP_BT    = 4'd3;
    localparam logic [OP_W-1:0] OP_BTC   = 4'd4;
    localparam logic [OP_W-1:0] OP_BTR   = 4'd5;
    localparam logic [OP_W-1:0] OP_BTS   = 4'd6;
    localparam logic [OP_W-1:0] OP_BSF   = 4'd7;
    localparam logic [OP_W-1:0] OP_BSR   = 4'd8;
    localparam logic [OP_W-1:0] OP_BSWAP = 4'd9;

    // operand size codes, the unused code behaves as dword
    localparam logic [SIZE_W-1:0] SIZE_BYTE  = 2'd0;
    localparam logic [SIZE_W-1:0] SIZE_WORD  = 2'd1;
    localparam logic [SIZE_W-1:0] SIZE_DWORD = 2'd2;

    // flag bit positions
    localparam int FLAG_CF = 0;
    localparam int FLAG_PF = 1;
    localparam int FLAG_AF = 2;
    localparam int FLAG_ZF = 3;
    localparam int FLAG_SF = 4;
    localparam int FLAG_OF = 5;

    // auxiliary carry is the carry into bit 4
    localparam int NIBBLE_CARRY_BIT = 4;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [SIZE_W-1:0]  size;
        logic [DATA_W-1:0]  operand_a;
        logic [DATA_W-1:0]  operand_b;
        logic [FLAGS_W-1:0] flags_in;
    } req_t;

    typedef struct packed {
        logic [DATA_W-1:0]  result;
        logic [FLAGS_W-1:0] flags_out;
        logic               write_result;
    } rsp_t;

endpackage

@@ sv/iabu_req_if.sv @@
// ----------------------------------------------------------------------------
// iabu_req_if: request channel of the integer ALU
// valid/ready handshake carrying one operation per transaction
// ----------------------------------------------------------------------------
interface iabu_req_if;
    logic           valid;
    logic           ready;
    iabu_pkg::req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ sv/iabu_rsp_if.sv @@
// ----------------------------------------------------------------------------
// iabu_rsp_if: response channel of the integer ALU
// valid/ready handshake carrying one result per transaction
// ----------------------------------------------------------------------------
interface iabu_rsp_if;
    logic           valid;
    logic           ready;
    iabu_pkg::rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ sv/integer_add_logic_bit_alu_unit.sv @@
// ----------------------------------------------------------------------------
// integer_add_logic_bit_alu_unit: add, logic, bit test, bit scan and bswap ALU
// path: a request passes through the input register and then the result
// register before its response is valid
// throughput: 1 transaction per cycle while rsp.ready is high, set by the input
// and result registers with ready flowing back through both stages
// reset: rst_n clears both stage valid bits, payload registers are not reset
// ----------------------------------------------------------------------------
module integer_add_logic_bit_alu_unit
(
    input  logic       clk,
    input  logic       rst_n,
    iabu_req_if.sink   req,
    iabu_rsp_if.source rsp
);

    localparam int DW = iabu_pkg::DATA_W;
    localparam int IW = iabu_pkg::IDX_W;

    // stage registers
    logic           in_valid_reg;
    iabu_pkg::req_t in_reg;
    logic           out_valid_reg;
    iabu_pkg::rsp_t out_reg;
    iabu_pkg::rsp_t out_next;

    logic out_load;
    logic in_load;

    // backpressure through the two stages
    assign out_load  = !out_valid_reg || rsp.ready;
    assign in_load   = !in_valid_reg || out_load;
    assign req.ready = in_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_load)
            begin
                in_valid_reg <= req.valid;
            end
            if (out_load)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load && req.valid)
        begin
            in_reg <= req.data;
        end
        if (out_load && in_valid_reg)
        begin
            out_reg <= out_next;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

    // lowest set bit index within one byte
    function automatic logic [2:0] byte_low(input logic [7:0] v);
        logic [2:0] idx;
        idx = 3'd0;
        for (int i = 7; i >= 0; i--)
        begin
            if (v[i])
            begin
                idx = 3'(i);
            end
        end
        return idx;
    endfunction

    // highest set bit index within one byte
    function automatic logic [2:0] byte_high(input logic [7:0] v);
        logic [2:0] idx;
        idx = 3'd0;
        for (int i = 0; i < 8; i++)
        begin
            if (v[i])
            begin
                idx = 3'(i);
            end
        end
        return idx;
    endfunction

    // operand width decode
    logic [DW-1:0] mask;
    logic [IW-1:0] top_bit;
    logic [IW-1:0] bit_off;

    always_comb
    begin
        unique case (in_reg.size)
            iabu_pkg::SIZE_BYTE:
            begin
                mask    = DW'(8'hff);
                top_bit = IW'(7);
                bit_off = IW'(in_reg.operand_b[2:0]);
            end
            iabu_pkg::SIZE_WORD:
            begin
                mask    = DW'(16'hffff);
                top_bit = IW'(15);
                bit_off = IW'(in_reg.operand_b[3:0]);
            end
            default:
            begin
                mask    = '1;
                top_bit = IW'(DW - 1);
                bit_off = in_reg.operand_b[IW-1:0];
            end
        endcase
    end

    // adder, shared by add and adc
    logic [DW-1:0] x;
    logic [DW-1:0] y;
    logic          cin;
    logic [DW:0]   sum;
    logic [DW-1:0] sum_res;
    logic          sum_carry;

    assign x       = in_reg.operand_a & mask;
    assign y       = in_reg.operand_b & mask;
    assign cin     = (in_reg.op == iabu_pkg::OP_ADC) && in_reg.flags_in[iabu_pkg::FLAG_CF];
    assign sum     = {1'b0, x} + {1'b0, y} + {{DW{1'b0}}, cin};
    assign sum_res = sum[DW-1:0] & mask;

    // carry out sits one bit above the top of the selected width
    always_comb
    begin
        unique case (in_reg.size)
            iabu_pkg::SIZE_BYTE: sum_carry = sum[8];
            iabu_pkg::SIZE_WORD: sum_carry = sum[16];
            default:             sum_carry = sum[DW];
        endcase
    end

    // bit scan over bytes, then across bytes
    logic [DW-1:0] scan_src;
    logic [3:0]    byte_any;
    logic [IW-1:0] bsf_idx;
    logic [IW-1:0] bsr_idx;

    assign scan_src = in_reg.operand_b & mask;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            byte_any[k] = |scan_src[8*k +: 8];
        end
        bsf_idx = '0;
        for (int k = 3; k >= 0; k--)
        begin
            if (byte_any[k])
            begin
                bsf_idx = {2'(k), byte_low(scan_src[8*k +: 8])};
            end
        end
        bsr_idx = '0;
        for (int k = 0; k < 4; k++)
        begin
            if (byte_any[k])
            begin
                bsr_idx = {2'(k), byte_high(scan_src[8*k +: 8])};
            end
        end
    end

    // operation select
    logic [DW-1:0]                bit_sel;
    logic [DW-1:0]                logic_res;
    logic [iabu_pkg::FLAGS_W-1:0] fin;
    logic [DW-1:0]                res;
    logic [iabu_pkg::FLAGS_W-1:0] fout;
    logic                         wr;

    assign bit_sel   = DW'(1) << bit_off;
    assign logic_res = in_reg.operand_a & in_reg.operand_b & mask;
    assign fin       = in_reg.flags_in;

    always_comb
    begin
        res  = x;
        fout = fin;
        wr   = 1'b0;
        unique case (in_reg.op)
            iabu_pkg::OP_ADD, iabu_pkg::OP_ADC:
            begin
                res                         = sum_res;
                fout                        = '0;
                fout[iabu_pkg::FLAG_CF]     = sum_carry;
                fout[iabu_pkg::FLAG_PF]     = ~^sum_res[7:0];
                fout[iabu_pkg::FLAG_AF]     = x[iabu_pkg::NIBBLE_CARRY_BIT]
                                              ^ y[iabu_pkg::NIBBLE_CARRY_BIT]
                                              ^ sum_res[iabu_pkg::NIBBLE_CARRY_BIT];
                fout[iabu_pkg::FLAG_ZF]     = (sum_res == '0);
                fout[iabu_pkg::FLAG_SF]     = sum_res[top_bit];
                fout[iabu_pkg::FLAG_OF]     = (x[top_bit] ^ sum_res[top_bit])
                                              & (y[top_bit] ^ sum_res[top_bit]);
                wr                          = 1'b1;
            end
            iabu_pkg::OP_AND:
            begin
                res                     = logic_res;
                fout                    = '0;
                fout[iabu_pkg::FLAG_PF] = ~^logic_res[7:0];
                fout[iabu_pkg::FLAG_AF] = fin[iabu_pkg::FLAG_AF];
                fout[iabu_pkg::FLAG_ZF] = (logic_res == '0);
                fout[iabu_pkg::FLAG_SF] = logic_res[top_bit];
                wr                      = 1'b1;
            end
            iabu_pkg::OP_BT, iabu_pkg::OP_BTC, iabu_pkg::OP_BTR, iabu_pkg::OP_BTS:
            begin
                fout[iabu_pkg::FLAG_CF] = x[bit_off];
                unique case (in_reg.op)
                    iabu_pkg::OP_BTC:
                    begin
                        res = x ^ bit_sel;
                        wr  = 1'b1;
                    end
                    iabu_pkg::OP_BTR:
                    begin
                        res = x & ~bit_sel;
                        wr  = 1'b1;
                    end
                    iabu_pkg::OP_BTS:
                    begin
                        res = x | bit_sel;
                        wr  = 1'b1;
                    end
                    default:
                    begin
                        res = x;
                        wr  = 1'b0;
                    end
                endcase
            end
            iabu_pkg::OP_BSF, iabu_pkg::OP_BSR:
            begin
                // zero source leaves the destination alone
                if (scan_src == '0)
                begin
                    fout[iabu_pkg::FLAG_ZF] = 1'b1;
                end
                else
                begin
                    fout[iabu_pkg::FLAG_ZF] = 1'b0;
                    res = DW'((in_reg.op == iabu_pkg::OP_BSF) ? bsf_idx : bsr_idx);
                    wr  = 1'b1;
                end
            end
            iabu_pkg::OP_BSWAP:
            begin
                res = {in_reg.operand_a[7:0], in_reg.operand_a[15:8],
                       in_reg.operand_a[23:16], in_reg.operand_a[31:24]};
                wr  = 1'b1;
            end
            default:
            begin
                // unused opcodes pass the destination and flags through
                res  = x;
                fout = fin;
                wr   = 1'b0;
            end
        endcase
    end

    assign out_next.result       = res;
    assign out_next.flags_out    = fout;
    assign out_next.write_result = wr;

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the integer add, logic, bit test and bit scan ALU
// drives operations over the request channel with random gaps, stalls the
// response channel at random and compares every response, field by field,
// against a local model of the arithmetic, logic, bit and byte-swap ops
// ----------------------------------------------------------------------------
module tb_top;

    // opcodes past bswap are no-ops, size code 3 acts as dword
    localparam logic [iabu_pkg::OP_W-1:0]   OP_UNUSED_LO  = 4'd10;
    localparam logic [iabu_pkg::OP_W-1:0]   OP_UNUSED_MID = 4'd12;
    localparam logic [iabu_pkg::OP_W-1:0]   OP_UNUSED_HI  = 4'd15;
    localparam logic [iabu_pkg::SIZE_W-1:0] SIZE_SPARE    = 2'd3;

    localparam int MAX_GAP        = 6;
    localparam int REPORT_LIMIT   = 10;
    localparam int DRAIN_LIMIT    = 2000;
    localparam int PIPE_LATENCY   = 2;

    logic clk;
    logic rst_n;

    iabu_req_if req_if ();
    iabu_rsp_if rsp_if ();

    integer_add_logic_bit_alu_unit u_top
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if.sink),
        .rsp   (rsp_if.source)
    );

    // results predicted for accepted operations, oldest first
    iabu_pkg::rsp_t pending_results[$];

    int  items_sent;
    int  results_checked;
    int  error_count;
    bit  no_idle;

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // safety net against a hung handshake
    initial
    begin
        #1ms;
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // sign, zero and parity flags of a masked result
    function automatic logic [iabu_pkg::FLAGS_W-1:0] szp_of(
        input logic [iabu_pkg::DATA_W-1:0] res,
        input int unsigned                 w);
        logic [iabu_pkg::FLAGS_W-1:0] f;
        f = '0;
        f[iabu_pkg::FLAG_SF] = res[w-1];
        f[iabu_pkg::FLAG_ZF] = (res == '0);
        f[iabu_pkg::FLAG_PF] = ~^res[7:0];
        return f;
    endfunction

    // expected response for one operation
    function automatic iabu_pkg::rsp_t alu_result_of(input iabu_pkg::req_t rq);
        iabu_pkg::rsp_t               r;
        int unsigned                  w;
        int unsigned                  off;
        int unsigned                  idx;
        logic [iabu_pkg::DATA_W-1:0]  m;
        logic [iabu_pkg::DATA_W-1:0]  x;
        logic [iabu_pkg::DATA_W-1:0]  y;
        logic [iabu_pkg::DATA_W-1:0]  res;
        logic [iabu_pkg::DATA_W-1:0]  ov;
        logic [iabu_pkg::DATA_W-1:0]  ac;
        logic [iabu_pkg::DATA_W:0]    sum;
        logic                         cin;
        logic [iabu_pkg::FLAGS_W-1:0] f;
        logic                         wr;
        case (rq.size)
            iabu_pkg::SIZE_BYTE: w = 8;
            iabu_pkg::SIZE_WORD: w = 16;
            default:             w = 32;
        endcase
        m   = (w == 32) ? {iabu_pkg::DATA_W{1'b1}} : ((32'h1 << w) - 32'h1);
        x   = rq.operand_a & m;
        y   = rq.operand_b & m;
        f   = rq.flags_in;
        res = x;
        wr  = 1'b0;
        case (rq.op)
            iabu_pkg::OP_ADD, iabu_pkg::OP_ADC:
            begin
                cin = (rq.op == iabu_pkg::OP_ADC) && rq.flags_in[iabu_pkg::FLAG_CF];
                sum = {1'b0, x} + {1'b0, y} + {{iabu_pkg::DATA_W{1'b0}}, cin};
                res = sum[iabu_pkg::DATA_W-1:0] & m;
                f   = szp_of(res, w);
                ov  = (x ^ res) & (y ^ res);
                ac  = x ^ y ^ res;
                f[iabu_pkg::FLAG_CF] = sum[w];
                f[iabu_pkg::FLAG_OF] = ov[w-1];
                f[iabu_pkg::FLAG_AF] = ac[iabu_pkg::NIBBLE_CARRY_BIT];
                wr  = 1'b1;
            end
            iabu_pkg::OP_AND:
            begin
                res = x & y;
                f   = szp_of(res, w);
                f[iabu_pkg::FLAG_AF] = rq.flags_in[iabu_pkg::FLAG_AF];
                wr  = 1'b1;
            end
            iabu_pkg::OP_BT, iabu_pkg::OP_BTC, iabu_pkg::OP_BTR, iabu_pkg::OP_BTS:
            begin
                off = rq.operand_b % w;
                f[iabu_pkg::FLAG_CF] = x[off];
                if (rq.op == iabu_pkg::OP_BTC)
                    res[off] = ~x[off];
                else if (rq.op == iabu_pkg::OP_BTR)
                    res[off] = 1'b0;
                else if (rq.op == iabu_pkg::OP_BTS)
                    res[off] = 1'b1;
                wr = (rq.op != iabu_pkg::OP_BT);
            end
            iabu_pkg::OP_BSF, iabu_pkg::OP_BSR:
            begin
                if (y == '0)
                begin
                    // zero scan source leaves the destination alone
                    f[iabu_pkg::FLAG_ZF] = 1'b1;
                end
                else
                begin
                    idx = 0;
                    if (rq.op == iabu_pkg::OP_BSF)
                    begin
                        for (int i = w - 1; i >= 0; i--)
                            if (y[i])
                                idx = i;
                    end
                    else
                    begin
                        for (int i = 0; i < w; i++)
                            if (y[i])
                                idx = i;
                    end
                    f[iabu_pkg::FLAG_ZF] = 1'b0;
                    res = iabu_pkg::DATA_W'(idx);
                    wr  = 1'b1;
                end
            end
            iabu_pkg::OP_BSWAP:
            begin
                res = {rq.operand_a[7:0], rq.operand_a[15:8],
                       rq.operand_a[23:16], rq.operand_a[31:24]};
                wr  = 1'b1;
            end
            default:
            begin
                // unused opcode: nothing changes
            end
        endcase
        r.result       = res;
        r.flags_out    = f;
        r.write_result = wr;
        return r;
    endfunction

    function automatic iabu_pkg::req_t build_op(
        input logic [iabu_pkg::OP_W-1:0]    op,
        input logic [iabu_pkg::SIZE_W-1:0]  size,
        input logic [iabu_pkg::DATA_W-1:0]  a,
        input logic [iabu_pkg::DATA_W-1:0]  b,
        input logic [iabu_pkg::FLAGS_W-1:0] f);
        iabu_pkg::req_t rq;
        rq.op        = op;
        rq.size      = size;
        rq.operand_a = a;
        rq.operand_b = b;
        rq.flags_in  = f;
        return rq;
    endfunction

    // operand biased toward width edges and single bits
    function automatic logic [iabu_pkg::DATA_W-1:0] pick_operand();
        logic [iabu_pkg::DATA_W-1:0] v;
        case ($urandom_range(0, 7))
            0: v = '0;
            1: v = {iabu_pkg::DATA_W{1'b1}};
            2: v = 32'h1 << $urandom_range(0, iabu_pkg::DATA_W - 1);
            3: v = ~(32'h1 << $urandom_range(0, iabu_pkg::DATA_W - 1));
            4:
            begin
                case ($urandom_range(0, 7))
                    0: v = 32'h0000007F;
                    1: v = 32'h00000080;
                    2: v = 32'h00007FFF;
                    3: v = 32'h00008000;
                    4: v = 32'h7FFFFFFF;
                    5: v = 32'h80000000;
                    6: v = 32'h000000FF;
                    default: v = 32'h0000FFFF;
                endcase
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic logic [iabu_pkg::SIZE_W-1:0] pick_size();
        if ($urandom_range(0, 7) == 0)
            return SIZE_SPARE;
        return iabu_pkg::SIZE_W'($urandom_range(iabu_pkg::SIZE_BYTE, iabu_pkg::SIZE_DWORD));
    endfunction

    function automatic logic [iabu_pkg::FLAGS_W-1:0] pick_flags();
        return iabu_pkg::FLAGS_W'($urandom_range(0, 63));
    endfunction

    // report a failure, printing only the first REPORT_LIMIT; later ones are only counted
    task automatic note_error(input string msg);
        error_count++;
        if (error_count <= REPORT_LIMIT)
            $display("ERROR: %s", msg);
    endtask

    // one request transaction after a random gap
    task automatic send_op(input iabu_pkg::req_t rq);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= rq;
        do
            @(posedge clk);
        while (!req_if.ready);
        items_sent++;
    endtask

    // response side: random stall before each transaction
    initial
    begin : rsp_ready_drive
        int gap;
        rsp_if.ready = 1'b0;
        forever
        begin
            gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
            if (gap != 0)
            begin
                rsp_if.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_if.valid);
        end
    end

    // check responses, then record the operation accepted at this edge
    always @(posedge clk)
    begin : result_check
        iabu_pkg::rsp_t want;
        iabu_pkg::rsp_t got;
        if (rst_n)
        begin
            if (rsp_if.valid && rsp_if.ready)
            begin
                got = rsp_if.data;
                if (pending_results.size() == 0)
                begin
                    note_error($sformatf("response with none expected: result %08h",
                                         got.result));
                end
                else
                begin
                    want = pending_results.pop_front();
                    results_checked++;
                    if (got.result !== want.result)
                        note_error($sformatf("result exp %08h act %08h",
                                             want.result, got.result));
                    if (got.flags_out !== want.flags_out)
                        note_error($sformatf("flags_out exp %02h act %02h (result %08h)",
                                             want.flags_out, got.flags_out, want.result));
                    if (got.write_result !== want.write_result)
                        note_error($sformatf("write_result exp %0b act %0b (result %08h)",
                                             want.write_result, got.write_result,
                                             want.result));
                end
            end
            if (req_if.valid && req_if.ready)
                pending_results.push_back(alu_result_of(req_if.data));
        end
    end

    // add and add-with-carry at the width edges
    task automatic test_add_edges();
        // byte carry out with zero result and nibble carry
        send_op(build_op(iabu_pkg::OP_ADD, iabu_pkg::SIZE_BYTE,
                         32'hFFFFFF_FF, 32'h00000001, 6'h00));
        // word signed overflow
        send_op(build_op(iabu_pkg::OP_ADD, iabu_pkg::SIZE_WORD,
                         32'h00007FFF, 32'h00000001, 6'h3F));
        // dword carry-in ripples all the way
        send_op(build_op(iabu_pkg::OP_ADC, iabu_pkg::SIZE_DWORD,
                         32'hFFFFFFFF, 32'h00000000, 6'h01));
        send_op(build_op(iabu_pkg::OP_ADD, iabu_pkg::SIZE_DWORD,
                         32'h00000000, 32'h00000000, 6'h3F));
        send_op(build_op(iabu_pkg::OP_ADC, iabu_pkg::SIZE_BYTE,
                         32'h1234567F, 32'hABCDEF01, 6'h3E));
        // unused size code behaves as dword
        send_op(build_op(iabu_pkg::OP_ADD, SIZE_SPARE, 32'h80000000, 32'h80000000, 6'h00));
    endtask

    task automatic test_and_edges();
        send_op(build_op(iabu_pkg::OP_AND, iabu_pkg::SIZE_BYTE,
                         32'hFFFFFF0F, 32'h000000F0, 6'h3F));
        send_op(build_op(iabu_pkg::OP_AND, iabu_pkg::SIZE_DWORD,
                         32'hFFFFFFFF, 32'hFFFFFFFF, 6'h00));
    endtask

    // bit test family, offsets wrap at the operand width
    task automatic test_bit_ops();
        send_op(build_op(iabu_pkg::OP_BT, iabu_pkg::SIZE_BYTE,
                         32'h00000080, 32'h0000000F, 6'h00));
        send_op(build_op(iabu_pkg::OP_BTC, iabu_pkg::SIZE_WORD,
                         32'hFFFF8000, 32'h0000001F, 6'h3F));
        send_op(build_op(iabu_pkg::OP_BTR, iabu_pkg::SIZE_DWORD,
                         32'hFFFFFFFF, 32'hFFFFFFFF, 6'h00));
        send_op(build_op(iabu_pkg::OP_BTS, iabu_pkg::SIZE_BYTE,
                         32'hFFFFFF00, 32'h00000003, 6'h3F));
        send_op(build_op(iabu_pkg::OP_BT, SIZE_SPARE, 32'h80000000, 32'h0000003F, 6'h00));
    endtask

    // scans, including sources that are zero at the operand width
    task automatic test_scans();
        send_op(build_op(iabu_pkg::OP_BSF, iabu_pkg::SIZE_DWORD,
                         32'hDEADBEEF, 32'h00000000, 6'h00));
        send_op(build_op(iabu_pkg::OP_BSR, iabu_pkg::SIZE_BYTE,
                         32'hCAFEF00D, 32'h00000100, 6'h37));
        send_op(build_op(iabu_pkg::OP_BSF, iabu_pkg::SIZE_WORD,
                         32'h00000000, 32'hFFFF8000, 6'h3F));
        send_op(build_op(iabu_pkg::OP_BSR, iabu_pkg::SIZE_DWORD,
                         32'h00000000, 32'hFFFFFFFF, 6'h08));
        send_op(build_op(iabu_pkg::OP_BSF, iabu_pkg::SIZE_BYTE,
                         32'hFFFFFFFF, 32'h00000001, 6'h2A));
    endtask

    // byte swap ignores the size, unused opcodes change nothing
    task automatic test_swap_and_unused();
        send_op(build_op(iabu_pkg::OP_BSWAP, iabu_pkg::SIZE_BYTE,
                         32'h12345678, 32'hFFFFFFFF, 6'h15));
        send_op(build_op(iabu_pkg::OP_BSWAP, SIZE_SPARE, 32'hFFFF0000, 32'h00000000, 6'h2A));
        send_op(build_op(OP_UNUSED_LO, iabu_pkg::SIZE_BYTE,
                         32'hFFFFFFFF, 32'hFFFFFFFF, 6'h3F));
        send_op(build_op(OP_UNUSED_HI, iabu_pkg::SIZE_WORD,
                         32'h89ABCDEF, 32'h01234567, 6'h00));
        send_op(build_op(OP_UNUSED_MID, iabu_pkg::SIZE_DWORD,
                         32'h0F0F0F0F, 32'h0, 6'h12));
    endtask

    // random operations over the whole opcode space
    task automatic test_random_mix(input int count);
        logic [iabu_pkg::OP_W-1:0] op;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 15) == 0)
                op = iabu_pkg::OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
            else
                op = iabu_pkg::OP_W'($urandom_range(iabu_pkg::OP_ADD, iabu_pkg::OP_BSWAP));
            send_op(build_op(op, pick_size(), pick_operand(), pick_operand(),
                             pick_flags()));
        end
    endtask

    // bit tests and scans with sparse sources and offsets past the width
    task automatic test_random_bits(input int count);
        logic [iabu_pkg::OP_W-1:0]   op;
        logic [iabu_pkg::DATA_W-1:0] b;
        for (int n = 0; n < count; n++)
        begin
            op = iabu_pkg::OP_W'($urandom_range(iabu_pkg::OP_BT, iabu_pkg::OP_BSR));
            case ($urandom_range(0, 3))
                0: b = $urandom_range(0, 63);
                1: b = (32'h1 << $urandom_range(0, iabu_pkg::DATA_W - 1))
                     | (32'h1 << $urandom_range(0, iabu_pkg::DATA_W - 1));
                2: b = pick_operand();
                default: b = $urandom;
            endcase
            send_op(build_op(op, pick_size(), pick_operand(), b, pick_flags()));
        end
    endtask

    // main sequence
    initial
    begin : main_seq
        int guard;
        rst_n         = 1'b0;
        req_if.valid  = 1'b0;
        req_if.data   = '0;
        no_idle       = 1'b0;
        items_sent    = 0;
        results_checked = 0;
        error_count   = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_add_edges();
        test_and_edges();
        test_bit_ops();
        test_scans();
        test_swap_and_unused();
        test_random_mix(900);

        // back-to-back stretch on both channels
        no_idle = 1'b1;
        test_random_mix(300);
        no_idle = 1'b0;

        test_random_bits(400);
        req_if.valid <= 1'b0;

        guard = 0;
        while (pending_results.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (PIPE_LATENCY + 8) @(posedge clk);
        if (pending_results.size() != 0)
            note_error($sformatf("%0d expected results never arrived",
                                 pending_results.size()));

        $display("sent %0d operations (add, adc, and, bit test, scan, bswap, unused)",
                 items_sent);
        $display("checked %0d responses, %0d errors", results_checked, error_count);
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/iabu_pkg.sv
sv/iabu_req_if.sv
sv/iabu_rsp_if.sv
sv/integer_add_logic_bit_alu_unit.sv
bench/tb_top.sv
